// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the frame checker RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ===== rtl/fxc_pkg.sv =====
// Shared types and constants for the frame XOR checker.
// Depends on nothing; imported by every module of the block.
`default_nettype none

package fxc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 512;

    localparam int BYTE_W    = 8;
    localparam int MINLEN_W  = 10;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int VERDICT_W = 2;
    localparam int FBYTES_W  = 10;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_START_MARKER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_MARKER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAME    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0]   START_MARKER_RST = 8'd2;
    localparam logic [BYTE_W-1:0]   END_MARKER_RST   = 8'd3;
    localparam logic [MINLEN_W-1:0] MIN_FRAME_RST    = 10'd5;

    // Verdict codes.
    localparam logic [VERDICT_W-1:0] VERDICT_VALID    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_FORMAT   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_CHECKSUM = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0]   start_marker;
        logic [BYTE_W-1:0]   end_marker;
        logic [MINLEN_W-1:0] min_frame_bytes;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } beat_t;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [FBYTES_W-1:0]  frame_bytes;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/frame_xor_check_top.sv =====
// A byte is judged in the input register; a verdict is held in the output register.
// Throughput: one byte per cycle, but a final byte waits while the output register is full.
// Reset (rst_n low, asynchronous) clears the frame state and both beat valid flags and
// loads start marker 2, end marker 3 and minimum frame length 5; no clearing pass follows.
`default_nettype none

module frame_xor_check_top
    import fxc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Byte channel.
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [BYTE_W-1:0]    data_byte,
    input  wire logic                 last_byte,
    // Verdict channel.
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [VERDICT_W-1:0]      verdict,
    output logic [FBYTES_W-1:0]       frame_bytes,
    // Configuration write port.
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    // The block runs as three steps. The input register holds an accepted beat.
    // The tracker applies that beat to the frame state: it keeps the count, the first
    // two bytes, a two-byte delay line and the running XOR, and on the final beat of
    // a frame it forms the verdict and clears its state. The output register holds
    // the verdict beat until the consumer takes it. Non-final beats never wait on the
    // output side, so bytes keep flowing while a verdict is still waiting to be read.

    cfg_t    cfg_reg;
    beat_t   beat;
    logic    beat_valid;
    logic    advance;
    logic    out_free;
    logic    result_load;
    result_t result;

    // Configuration registers. Writes to an index beyond the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_marker    <= START_MARKER_RST;
            cfg_reg.end_marker      <= END_MARKER_RST;
            cfg_reg.min_frame_bytes <= MIN_FRAME_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_START_MARKER: cfg_reg.start_marker    <= cfg_data[BYTE_W-1:0];
                REG_END_MARKER:   cfg_reg.end_marker      <= cfg_data[BYTE_W-1:0];
                REG_MIN_FRAME:    cfg_reg.min_frame_bytes <= cfg_data[MINLEN_W-1:0];
                default:          cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    fxc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .advance    (advance),
        .beat_valid (beat_valid),
        .beat       (beat)
    );

    fxc_tracker #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .beat_valid  (beat_valid),
        .beat        (beat),
        .out_free    (out_free),
        .advance     (advance),
        .result_load (result_load),
        .result      (result)
    );

    fxc_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .result_load (result_load),
        .result      (result),
        .out_free    (out_free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .verdict     (verdict),
        .frame_bytes (frame_bytes)
    );

endmodule

`default_nettype wire

// ===== rtl/fxc_in_stage.sv =====
// Input register of the frame XOR checker: holds one beat until the tracker takes it.
// Depends on fxc_pkg.
`default_nettype none

module fxc_in_stage
    import fxc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [BYTE_W-1:0] data_byte,
    input  wire logic              last_byte,
    input  wire logic              advance,
    output logic                   beat_valid,
    output beat_t                  beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;

    // The stage takes a new beat when empty or when its beat moves on this cycle.
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            beat_reg.data_byte <= data_byte;
            beat_reg.last_byte <= last_byte;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

`default_nettype wire

// ===== rtl/fxc_tracker.sv =====
// Frame state of the checker: byte count, head and length bytes, delay line,
// running XOR, and the verdict on the final byte. Depends on fxc_pkg.
`default_nettype none

`include "assert_macros.svh"

module fxc_tracker
    import fxc_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  beat_valid,
    input  wire beat_t beat,
    input  wire logic  out_free,
    output logic       advance,
    output logic       result_load,
    output result_t    result
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (CNT_W > MINLEN_W) ? CNT_W : MINLEN_W;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_FRAME_BYTES);

    logic [CNT_W-1:0]  count_reg,  count_next;
    logic [BYTE_W-1:0] xor_reg,    xor_next;
    logic [BYTE_W-1:0] head_reg,   head_next;
    logic [BYTE_W-1:0] len_reg,    len_next;
    logic [BYTE_W-1:0] d1_reg,     d1_next;
    logic [BYTE_W-1:0] d2_reg,     d2_next;
    logic              ovf_reg,    ovf_next;

    logic [CMP_W-1:0]     count_w;
    logic [VERDICT_W-1:0] verdict;

    // A non-final beat always moves on; a final beat needs room in the output register.
    assign advance     = beat_valid && (!beat.last_byte || out_free);
    assign result_load = advance && beat.last_byte;

    // Per-byte update, as if the byte is not the last one.
    always_comb
    begin
        head_next  = (count_reg == CNT_W'(0)) ? beat.data_byte : head_reg;
        len_next   = (count_reg == CNT_W'(1)) ? beat.data_byte : len_reg;
        xor_next   = (count_reg >= CNT_W'(3)) ? (xor_reg ^ d2_reg) : xor_reg;
        d2_next    = d1_reg;
        d1_next    = beat.data_byte;
        count_next = (count_reg < CNT_MAX) ? (count_reg + CNT_W'(1)) : count_reg;
        ovf_next   = ovf_reg || (count_reg == CNT_MAX);
    end

    // Verdict on the updated state; the first failing check decides.
    always_comb
    begin
        count_w = CMP_W'(count_next);
        if (count_w < CMP_W'(cfg.min_frame_bytes))
        begin
            verdict = VERDICT_FORMAT;
        end
        else if (head_next != cfg.start_marker || beat.data_byte != cfg.end_marker)
        begin
            verdict = VERDICT_FORMAT;
        end
        else if (count_w < CMP_W'(4) || ovf_next ||
                 CMP_W'(len_next) != (count_w - CMP_W'(4)))
        begin
            verdict = VERDICT_FORMAT;
        end
        else if (d2_next != xor_next)
        begin
            verdict = VERDICT_CHECKSUM;
        end
        else
        begin
            verdict = VERDICT_VALID;
        end
    end

    assign result.verdict     = verdict;
    assign result.frame_bytes = count_w[FBYTES_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            xor_reg   <= '0;
            head_reg  <= '0;
            len_reg   <= '0;
            d1_reg    <= '0;
            d2_reg    <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (advance)
        begin
            if (beat.last_byte)
            begin
                count_reg <= '0;
                xor_reg   <= '0;
                head_reg  <= '0;
                len_reg   <= '0;
                d1_reg    <= '0;
                d2_reg    <= '0;
                ovf_reg   <= 1'b0;
            end
            else
            begin
                count_reg <= count_next;
                xor_reg   <= xor_next;
                head_reg  <= head_next;
                len_reg   <= len_next;
                d1_reg    <= d1_next;
                d2_reg    <= d2_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // A judged frame leaves the tracker empty for the next one.
    `ASSERT_NEXT(a_clear_after_verdict, clk, rst_n, result_load, count_reg == '0 && !ovf_reg)
    // The overflow flag is only ever set once the count has saturated.
    `ASSERT_IMPLIES(a_ovf_saturated, clk, rst_n, ovf_reg, count_reg == CNT_MAX)
    // A final beat is never dropped while the output register is full.
    `ASSERT_IMPLIES(a_no_drop, clk, rst_n, result_load, out_free)

endmodule

`default_nettype wire

// ===== rtl/fxc_out_stage.sv =====
// Output register of the frame XOR checker: holds one verdict until it is taken.
// Depends on fxc_pkg.
`default_nettype none

`include "assert_macros.svh"

module fxc_out_stage
    import fxc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 result_load,
    input  wire result_t              result,
    output logic                      out_free,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [VERDICT_W-1:0]      verdict,
    output logic [FBYTES_W-1:0]       frame_bytes
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign out_free   = !valid_reg || out_ready;
    assign valid_next = result_load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid   = valid_reg;
    assign verdict     = result_reg.verdict;
    assign frame_bytes = result_reg.frame_bytes;

    // Only the three defined verdict codes ever leave the block.
    `ASSERT_IMPLIES(a_verdict_code, clk, rst_n, valid_reg, result_reg.verdict <= VERDICT_CHECKSUM)

endmodule

`default_nettype wire

// ===== test/frame_xor_check_top_tb.sv =====
// Self-checking testbench for frame_xor_check_top: directed and random frames against
// an in-bench predictor, under random gaps and stalls on both channels.
// Depends on fxc_pkg and frame_xor_check_top only.
`timescale 1ns / 1ps

module frame_xor_check_top_tb;
    import fxc_pkg::*;

    localparam int FRAME_CAP    = MAX_FRAME_BYTES_DEF;
    localparam int DRAIN_CYCLES = 4;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int PHASES       = 8;

    // The configuration port decodes two index bits, so one index names no register.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // Ways in which a generated frame departs from a well-formed one.
    typedef enum int {
        FLAW_NONE,
        FLAW_START,
        FLAW_END,
        FLAW_LENGTH,
        FLAW_SUM,
        FLAW_PAYLOAD,
        FLAW_EARLY_END
    } flaw_e;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 last_byte = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [VERDICT_W-1:0] verdict;
    logic [FBYTES_W-1:0]  frame_bytes;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    frame_xor_check_top #(.MAX_FRAME_BYTES(FRAME_CAP)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .verdict     (verdict),
        .frame_bytes (frame_bytes),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #4 clk = ~clk;

    // Beats waiting to be driven, and the verdicts that accepted frames must produce.
    beat_t   bytes_to_send[$];
    result_t verdicts_due[$];

    // Mirror of the configuration registers, updated as each write lands.
    logic [BYTE_W-1:0]   cfg_start = START_MARKER_RST;
    logic [BYTE_W-1:0]   cfg_end   = END_MARKER_RST;
    logic [MINLEN_W-1:0] cfg_min   = MIN_FRAME_RST;

    // Frame state of the predictor. All of it returns to zero after each verdict.
    int                frm_count = 0;
    logic [BYTE_W-1:0] frm_head  = '0;
    logic [BYTE_W-1:0] frm_len   = '0;
    logic [BYTE_W-1:0] frm_d1    = '0;
    logic [BYTE_W-1:0] frm_d2    = '0;
    logic [BYTE_W-1:0] frm_xor   = '0;
    logic              frm_ovf   = 1'b0;

    int      bad_verdicts = 0;
    int      cycles_run = 0;
    logic    in_took = 1'b0;
    int      in_gap = 0;
    int      in_calm = 0;
    int      out_stall = 0;
    int      out_calm = 0;
    beat_t   next_beat;
    result_t want;

    // Updates the predicted frame state with one accepted byte. On the final byte of a
    // frame it works out the verdict; the first failing check decides it.
    task judge_byte(input logic [BYTE_W-1:0] b, input logic fin);
        int                   cnt;
        logic [BYTE_W-1:0]    first;
        logic [VERDICT_W-1:0] v_code;
        result_t              res;
        if (frm_count == 0)
            frm_head = b;
        else if (frm_count == 1)
            frm_len = b;
        // Bytes 1 through count-3 enter the XOR once they have passed the two-byte delay.
        if (frm_count >= 3)
            frm_xor = frm_xor ^ frm_d2;
        frm_d2 = frm_d1;
        frm_d1 = b;
        if (frm_count < FRAME_CAP)
            frm_count = frm_count + 1;
        else
            frm_ovf = 1'b1;
        if (fin)
        begin
            cnt = frm_count;
            // In a one-byte frame the only byte is both the head and the tail.
            first = (cnt == 1) ? b : frm_head;
            if (cnt < cfg_min)
                v_code = VERDICT_FORMAT;
            else if (first != cfg_start || b != cfg_end)
                v_code = VERDICT_FORMAT;
            else if (cnt < 4 || frm_ovf || int'(frm_len) != cnt - 4)
                v_code = VERDICT_FORMAT;
            else if (frm_d2 != frm_xor)
                v_code = VERDICT_CHECKSUM;
            else
                v_code = VERDICT_VALID;
            res.verdict = v_code;
            res.frame_bytes = FBYTES_W'(cnt);
            verdicts_due.push_back(res);
            frm_count = 0;
            frm_head = '0;
            frm_len = '0;
            frm_d1 = '0;
            frm_d2 = '0;
            frm_xor = '0;
            frm_ovf = 1'b0;
        end
    endtask

    task log_mismatch(input string what);
        bad_verdicts = bad_verdicts + 1;
        if (bad_verdicts <= 10)
            $display("mismatch at cycle %0d: %s", cycles_run, what);
    endtask

    function automatic int draw_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task push_beat(input logic [BYTE_W-1:0] b, input logic fin);
        beat_t bt;
        bt.data_byte = b;
        bt.last_byte = fin;
        bytes_to_send.push_back(bt);
    endtask

    // Builds a frame of n bytes (n of at least four) with the current markers, a length
    // byte of n-4, random payload and a correct checksum, then applies one flaw.
    task queue_frame(input int n, input flaw_e flaw);
        logic [BYTE_W-1:0] fb[$];
        logic [BYTE_W-1:0] sum;
        int                cut;
        fb.delete();
        fb.push_back(cfg_start);
        fb.push_back(BYTE_W'(n - 4));
        // A bad length byte is covered by the checksum, so only the length check trips.
        if (flaw == FLAW_LENGTH)
            fb[1] = fb[1] ^ BYTE_W'($urandom_range(1, 255));
        for (int i = 4; i < n; i++)
            fb.push_back(BYTE_W'($urandom));
        sum = '0;
        for (int i = 1; i < fb.size(); i++)
            sum = sum ^ fb[i];
        fb.push_back(sum);
        fb.push_back(cfg_end);
        case (flaw)
            FLAW_START:   fb[0] = fb[0] ^ BYTE_W'($urandom_range(1, 255));
            FLAW_END:     fb[n-1] = fb[n-1] ^ BYTE_W'($urandom_range(1, 255));
            FLAW_SUM:     fb[n-2] = fb[n-2] ^ BYTE_W'($urandom_range(1, 255));
            FLAW_PAYLOAD:
            begin
                cut = $urandom_range(1, n - 3);
                fb[cut] = fb[cut] ^ BYTE_W'($urandom_range(1, 255));
            end
            default: ;
        endcase
        // A frame that ends early carries its last flag on some earlier byte.
        cut = (flaw == FLAW_EARLY_END) ? $urandom_range(0, n - 2) : n - 1;
        for (int i = 0; i <= cut; i++)
            push_beat(fb[i], i == cut);
    endtask

    // Waits until every beat is in and every verdict is out, then lets the pipeline drain.
    task settle();
        while (bytes_to_send.size() != 0 || verdicts_due.size() != 0 || in_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write, set up at the falling edge and taken at the next rising edge.
    task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_START_MARKER: cfg_start = val[BYTE_W-1:0];
            REG_END_MARKER:   cfg_end = val[BYTE_W-1:0];
            REG_MIN_FRAME:    cfg_min = val[MINLEN_W-1:0];
            default: ;
        endcase
    endtask

    // Byte channel driver. A beat that has been offered stays put until it is taken;
    // after each accepted beat a random gap may follow, except during calm stretches.
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!(in_valid && !in_took))
        begin
            if (in_valid)
            begin
                if (in_calm > 0)
                begin
                    in_calm = in_calm - 1;
                    in_gap = 0;
                end
                else
                begin
                    in_gap = draw_pause();
                    if ($urandom_range(0, 63) == 0)
                        in_calm = $urandom_range(20, 80);
                end
            end
            if (in_gap > 0)
            begin
                in_gap = in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (bytes_to_send.size() > 0)
            begin
                next_beat = bytes_to_send.pop_front();
                in_valid  <= 1'b1;
                data_byte <= next_beat.data_byte;
                last_byte <= next_beat.last_byte;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Verdict channel backpressure: random stalls of mostly short length, with calm
    // stretches where ready stays high.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_stall > 0)
        begin
            out_stall = out_stall - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (out_calm > 0)
                out_calm = out_calm - 1;
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    out_stall = draw_pause();
                if ($urandom_range(0, 63) == 0)
                    out_calm = $urandom_range(20, 80);
            end
        end
    end

    // Monitor. Every accepted byte beat feeds the predictor, and every accepted verdict
    // beat is checked against the oldest verdict still due. A cycle budget guards the run.
    always @(posedge clk)
    begin
        cycles_run = cycles_run + 1;
        if (cycles_run > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            in_took <= in_valid && in_ready;
            if (rst_n)
            begin
                if (in_valid && in_ready)
                    judge_byte(data_byte, last_byte);
                if (out_valid && out_ready)
                begin
                    if (verdicts_due.size() == 0)
                        log_mismatch($sformatf("unexpected verdict %0d, frame_bytes %0d",
                                               verdict, frame_bytes));
                    else
                    begin
                        want = verdicts_due.pop_front();
                        if (verdict !== want.verdict || frame_bytes !== want.frame_bytes)
                            log_mismatch($sformatf(
                                "expected verdict %0d bytes %0d, got verdict %0d bytes %0d",
                                want.verdict, want.frame_bytes, verdict, frame_bytes));
                    end
                end
            end
        end
    end

    // Stimulus: a directed opening under the reset configuration, then several phases,
    // each with its own register settings and a batch of random frames.
    initial
    begin
        int                  fill_goal;
        int                  pick;
        int                  len;
        logic [BYTE_W-1:0]   s_mark;
        logic [BYTE_W-1:0]   e_mark;
        logic [MINLEN_W-1:0] m_len;

        // Reset markers are 2 and 3 with a five-byte minimum.
        // A valid frame whose payload holds the all-ones byte; its checksum is 01 ^ FF.
        push_beat(8'h02, 0); push_beat(8'h01, 0); push_beat(8'hFF, 0);
        push_beat(8'hFE, 0); push_beat(8'h03, 1);
        // A one-byte frame made of the end marker alone: too short.
        push_beat(8'h03, 1);
        // Correct format, but the checksum byte disagrees with the XOR.
        push_beat(8'h02, 0); push_beat(8'h01, 0); push_beat(8'h00, 0);
        push_beat(8'h55, 0); push_beat(8'h03, 1);
        // Wrong start marker (the zero byte) with an otherwise consistent frame.
        push_beat(8'h00, 0); push_beat(8'h01, 0); push_beat(8'h00, 0);
        push_beat(8'h01, 0); push_beat(8'h03, 1);
        // Wrong end marker.
        push_beat(8'h02, 0); push_beat(8'h01, 0); push_beat(8'h80, 0);
        push_beat(8'h81, 0); push_beat(8'hFF, 1);
        // The length byte says two where the frame carries one payload byte.
        push_beat(8'h02, 0); push_beat(8'h02, 0); push_beat(8'h00, 0);
        push_beat(8'h02, 0); push_beat(8'h03, 1);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 1; phase <= PHASES; phase++)
        begin
            settle();
            s_mark = BYTE_W'($urandom);
            e_mark = BYTE_W'($urandom);
            m_len  = MINLEN_W'($urandom_range(0, 30));
            case (phase)
                1:
                begin
                    s_mark = '0;
                    e_mark = '1;
                    m_len  = '0;
                end
                2:
                begin
                    s_mark = '1;
                    e_mark = '0;
                    m_len  = MINLEN_W'(FRAME_CAP);
                end
                // Equal markers let a one-byte frame pass the marker check.
                3:
                begin
                    e_mark = s_mark;
                    m_len  = MINLEN_W'(1);
                end
                4: m_len = MINLEN_W'(4);
                5: m_len = MINLEN_W'(259);
                7: m_len = MINLEN_W'($urandom_range(600, 1023));
                8:
                begin
                    s_mark = START_MARKER_RST;
                    e_mark = END_MARKER_RST;
                    m_len  = MIN_FRAME_RST;
                end
                default: ;
            endcase
            // Upper data bits are don't-care for the marker registers; drive them randomly.
            write_reg(REG_START_MARKER, {2'($urandom_range(0, 3)), s_mark});
            write_reg(REG_END_MARKER, {2'($urandom_range(0, 3)), e_mark});
            write_reg(REG_MIN_FRAME, m_len);
            if (phase % 2 == 1)
                write_reg(REG_UNUSED, CFG_W'($urandom));
            @(negedge clk);
            cfg_wr_en <= 1'b0;

            // Two long frames: exactly the cap, and one that saturates the count.
            if (phase == 2)
                queue_frame(FRAME_CAP, FLAW_NONE);
            if (phase == 4)
                queue_frame(FRAME_CAP + 18, FLAW_NONE);

            fill_goal = bytes_to_send.size() + 40;
            while (bytes_to_send.size() < fill_goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // Noise: short runs of random bytes, often landing on a marker value.
                    len = $urandom_range(1, 12);
                    for (int i = 0; i < len; i++)
                        push_beat(($urandom_range(0, 3) == 0) ?
                                  (($urandom_range(0, 1) == 1) ? cfg_start : cfg_end) :
                                  BYTE_W'($urandom), i == len - 1);
                end
                else
                begin
                    len = (pick < 85) ? $urandom_range(4, 24) : $urandom_range(25, 259);
                    pick = $urandom_range(0, 11);
                    queue_frame(len, (pick < 6) ? FLAW_NONE : flaw_e'(pick - 5));
                end
            end
        end

        settle();
        if (bad_verdicts == 0 && verdicts_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/fxc_pkg.sv
rtl/fxc_in_stage.sv
rtl/fxc_tracker.sv
rtl/fxc_out_stage.sv
rtl/frame_xor_check_top.sv
test/frame_xor_check_top_tb.sv
